// File: sv/cec2d_pkg.sv
// shared types, request and register codes for the clamped-edge 2d convolution
// no dependencies; imported by every module of the block
package cec2d_pkg;

   localparam int DEF_MAX_WIDTH    = 1024;
   localparam int DEF_MAX_KERNEL   = 7;
   localparam int DEF_MAX_CHANNELS = 3;
   localparam int NUM_LANES        = 3;
   localparam int MAX_HEIGHT       = 4096;
   localparam int ACC_W            = 40;

   typedef logic [15:0]                   sample_type;
   typedef sample_type [NUM_LANES-1:0]    pixel_type;
   typedef logic signed [15:0]            coef_type;
   typedef logic signed [32:0]            prod_type;
   typedef prod_type [NUM_LANES-1:0]      prod_lanes_type;
   typedef logic signed [ACC_W-1:0]       acc_type;
   typedef acc_type [NUM_LANES-1:0]       acc_lanes_type;
   typedef logic [NUM_LANES-1:0]          lane_mask_type;

   // marks that travel with each kernel tap down the datapath
   typedef struct packed {
      logic shift;
      logic row_end;
      logic first_row;
      logic out_end;
   } tap_flags_type;

   typedef enum logic [1:0] {
      REQ_COEF  = 2'd0,
      REQ_PIXEL = 2'd1,
      REQ_DRAIN = 2'd2
   } req_code_type;

   localparam logic [2:0] CSR_IMG_WIDTH     = 3'd0;
   localparam logic [2:0] CSR_IMG_HEIGHT    = 3'd1;
   localparam logic [2:0] CSR_KERNEL_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_KERNEL_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_NUM_CHANNELS  = 3'd4;
   localparam logic [2:0] CSR_KEEP_CHANNELS = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ISSUE,
      ST_WAIT,
      ST_EMIT
   } state_type;

endpackage

// File: sv/clamped_edge_conv2d.sv
// top level of the clamped-edge 2d convolution: registers, line and coefficient
// memories, tap sequencer and result register; uses cec2d_pkg and cec2d_chain
//
//   port group | direction | handshake            | carries
//   req_*      | in        | req_valid/req_stall  | coefficient load, pixel or drain
//   rsp_*      | out       | rsp_valid/rsp_stall  | one output pixel per transfer
//   csr_*      | in        | csr_we               | register write, no read-back
//
// a coefficient load, a dropped pixel or an empty drain leaves the block idle; a pixel that
// releases no output passes through the readiness check only. each output takes the
// readiness check, kernel_width*kernel_height taps, the pipeline wait and the hand-off;
// the single line memory read port feeds one tap a cycle into the cell chain;
// up to four outputs follow a pixel.
// reset clears pointers and control only; memories are undefined until written.
// a stalled result holds in the output register; the next request is taken meanwhile.
module clamped_edge_conv2d #(
   parameter int MAX_WIDTH    = cec2d_pkg::DEF_MAX_WIDTH,
   parameter int MAX_KERNEL   = cec2d_pkg::DEF_MAX_KERNEL,
   parameter int MAX_CHANNELS = cec2d_pkg::DEF_MAX_CHANNELS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [12:0]         csr_wdata,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_type,
   input  logic [5:0]          req_coef_index,
   input  logic signed [15:0]  req_coef_value,
   input  logic [15:0]         req_pix_ch0,
   input  logic [15:0]         req_pix_ch1,
   input  logic [15:0]         req_pix_ch2,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [39:0]  rsp_out_ch0,
   output logic signed [39:0]  rsp_out_ch1,
   output logic signed [39:0]  rsp_out_ch2,
   output logic [9:0]          rsp_out_x,
   output logic [11:0]         rsp_out_y,
   output logic                rsp_last_of_run,
   output logic                rsp_frame_end
);
   import cec2d_pkg::*;

   localparam int XW         = $clog2(MAX_WIDTH);
   localparam int XW1        = XW + 1;
   localparam int TXW        = XW + 2;
   localparam int TYW        = 14;
   localparam int RGW        = $clog2(MAX_KERNEL);
   localparam int RGW1       = RGW + 1;
   localparam int LS_DEPTH   = MAX_KERNEL * MAX_WIDTH;
   localparam int LAW        = $clog2(LS_DEPTH);
   localparam int COEF_DEPTH = MAX_KERNEL * MAX_KERNEL;
   localparam int CAW        = $clog2(COEF_DEPTH);
   localparam int NC_MAX     = (MAX_CHANNELS < 3) ? MAX_CHANNELS : 3;

   // configuration
   logic [10:0] img_width_ff;
   logic [12:0] img_height_ff;
   logic [2:0]  kernel_width_ff, kernel_height_ff;
   logic [1:0]  num_channels_ff;
   logic        keep_channels_ff;

   logic [XW-1:0] wm1;
   logic [11:0]   hm1;
   logic [2:0]    kw, kh, kw_half, kh_half, ra, rb;
   logic [1:0]    nc;
   lane_mask_type lane_en;
   logic          geo_wr;

   // frame pointers
   logic [XW-1:0]  in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [11:0]    in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [RGW-1:0] in_ring_ff, in_ring_in, out_ring_ff, out_ring_in;
   logic           full_ff, full_in;
   logic [XW-1:0]  pix_col_ff, pix_col_in;
   logic [11:0]    pix_row_ff, pix_row_in;
   logic           drain_ff, drain_in;
   logic [1:0]     cnt_ff, cnt_in;
   state_type      state_ff, state_in;

   // tap sequencer
   logic [2:0]            i_ff, i_in, j_ff, j_in;
   logic signed [TXW-1:0] tx_ff, tx_in, tx0_ff, tx0_in, tx_init;
   logic signed [TYW-1:0] ty_ff, ty_in, ty_init;
   logic [RGW-1:0]        ring_ff, ring_in;
   logic [CAW-1:0]        caddr_ff, caddr_in;
   tap_flags_type         tap_in, s1_ff;
   logic [XW-1:0]         sx;
   logic [LAW-1:0]        ls_raddr, ls_waddr;

   // memories
   pixel_type ls_mem [LS_DEPTH];
   coef_type  coef_mem [COEF_DEPTH];
   pixel_type ls_rd_ff;
   coef_type  cf_rd_ff;
   logic      accept, ls_we, cf_we;

   // results
   logic          res_valid;
   acc_lanes_type res;
   logic          rsp_load, rsp_last_in, frame_end;
   logic [XW-1:0] nxt_col;
   logic [11:0]   nxt_row;
   logic [RGW-1:0] nxt_ring;
   logic          rsp_valid_ff;
   acc_type       rsp_ch0_ff, rsp_ch1_ff, rsp_ch2_ff;
   logic [9:0]    rsp_x_ff;
   logic [11:0]   rsp_y_ff;
   logic          rsp_last_ff, rsp_fe_ff;

   function automatic logic [RGW-1:0] ring_inc(input logic [RGW-1:0] r);
      return (r == RGW'(MAX_KERNEL - 1)) ? '0 : RGW'(r + 1'b1);
   endfunction

   // has the input reached the bottom-right pixel of this output's window
   function automatic logic out_ready(input logic [XW-1:0] ocol, input logic [11:0] orow);
      logic [12:0]  ny;
      logic [XW:0]  nx;
      ny = {1'b0, orow} + 13'(rb);
      if (ny > {1'b0, hm1}) ny = {1'b0, hm1};
      nx = {1'b0, ocol} + XW1'(ra);
      if (nx > {1'b0, wm1}) nx = {1'b0, wm1};
      return (ny < {1'b0, pix_row_ff}) ||
             ((ny == {1'b0, pix_row_ff}) && (nx <= {1'b0, pix_col_ff}));
   endfunction

   // effective geometry, clamped to the supported range
   always_comb begin
      if (img_width_ff == '0) begin
         wm1 = '0;
      end else if (32'(img_width_ff) > MAX_WIDTH) begin
         wm1 = XW'(MAX_WIDTH - 1);
      end else begin
         wm1 = XW'(img_width_ff - 11'd1);
      end
      if (img_height_ff == '0) begin
         hm1 = '0;
      end else if (img_height_ff > 13'(MAX_HEIGHT)) begin
         hm1 = 12'(MAX_HEIGHT - 1);
      end else begin
         hm1 = 12'(img_height_ff - 13'd1);
      end
      if (kernel_width_ff == '0) begin
         kw = 3'd1;
      end else if (32'(kernel_width_ff) > MAX_KERNEL) begin
         kw = 3'(MAX_KERNEL);
      end else begin
         kw = kernel_width_ff;
      end
      if (kernel_height_ff == '0) begin
         kh = 3'd1;
      end else if (32'(kernel_height_ff) > MAX_KERNEL) begin
         kh = 3'(MAX_KERNEL);
      end else begin
         kh = kernel_height_ff;
      end
      if (num_channels_ff == '0) begin
         nc = 2'd1;
      end else if (32'(num_channels_ff) > NC_MAX) begin
         nc = 2'(NC_MAX);
      end else begin
         nc = num_channels_ff;
      end
      for (int l = 0; l < NUM_LANES; l++) begin
         lane_en[l] = (l < int'(nc));
      end
      kw_half = kw >> 1;
      kh_half = kh >> 1;
      ra      = 3'(kw - 3'd1 - kw_half);
      rb      = 3'(kh - 3'd1 - kh_half);
   end

   assign geo_wr = csr_we && ((csr_index == CSR_IMG_WIDTH) || (csr_index == CSR_IMG_HEIGHT) ||
                   (csr_index == CSR_KERNEL_WIDTH) || (csr_index == CSR_KERNEL_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         img_width_ff     <= 11'd640;
         img_height_ff    <= 13'd480;
         kernel_width_ff  <= 3'd3;
         kernel_height_ff <= 3'd3;
         num_channels_ff  <= 2'd3;
         keep_channels_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMG_WIDTH:     img_width_ff     <= csr_wdata[10:0];
            CSR_IMG_HEIGHT:    img_height_ff    <= csr_wdata;
            CSR_KERNEL_WIDTH:  kernel_width_ff  <= csr_wdata[2:0];
            CSR_KERNEL_HEIGHT: kernel_height_ff <= csr_wdata[2:0];
            CSR_NUM_CHANNELS:  num_channels_ff  <= csr_wdata[1:0];
            CSR_KEEP_CHANNELS: keep_channels_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // tap addressing
   always_comb begin
      if (tx_ff[TXW-1]) begin
         sx = '0;
      end else if (tx_ff > $signed({2'b0, wm1})) begin
         sx = wm1;
      end else begin
         sx = tx_ff[XW-1:0];
      end
      ls_raddr = LAW'(LAW'(ring_ff) * LAW'(MAX_WIDTH) + LAW'(sx));
      ls_waddr = LAW'(LAW'(in_ring_ff) * LAW'(MAX_WIDTH) + LAW'(in_col_ff));
      tx_init  = $signed({2'b0, out_col_ff}) - $signed(TXW'(kw_half));
      ty_init  = $signed({2'b0, out_row_ff}) - $signed(TYW'(kh_half));
   end

   assign accept = req_valid && !req_stall;
   assign ls_we  = accept && (req_type == REQ_PIXEL) && !full_ff;
   assign cf_we  = accept && (req_type == REQ_COEF) && (32'(req_coef_index) < COEF_DEPTH);

   always_ff @(posedge clock) begin
      if (ls_we) begin
         ls_mem[ls_waddr] <= pixel_type'({req_pix_ch2, req_pix_ch1, req_pix_ch0});
      end
      if (cf_we) begin
         coef_mem[CAW'(req_coef_index)] <= req_coef_value;
      end
      ls_rd_ff <= ls_mem[ls_raddr];
      cf_rd_ff <= coef_mem[caddr_ff];
   end

   // next output position
   always_comb begin
      frame_end = (out_col_ff == wm1) && (out_row_ff == hm1);
      if (out_col_ff == wm1) begin
         nxt_col  = '0;
         nxt_row  = 12'(out_row_ff + 1'b1);
         nxt_ring = ring_inc(out_ring_ff);
      end else begin
         nxt_col  = XW'(out_col_ff + 1'b1);
         nxt_row  = out_row_ff;
         nxt_ring = out_ring_ff;
      end
   end

   always_comb begin
      state_in    = state_ff;
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_ring_in  = in_ring_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_ring_in = out_ring_ff;
      full_in     = full_ff;
      pix_col_in  = pix_col_ff;
      pix_row_in  = pix_row_ff;
      drain_in    = drain_ff;
      cnt_in      = cnt_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      tx_in       = tx_ff;
      tx0_in      = tx0_ff;
      ty_in       = ty_ff;
      ring_in     = ring_ff;
      caddr_in    = caddr_ff;
      tap_in      = '0;
      rsp_load    = 1'b0;
      rsp_last_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_type)
                  REQ_PIXEL: begin
                     if (!full_ff) begin
                        pix_col_in = in_col_ff;
                        pix_row_in = in_row_ff;
                        drain_in   = 1'b0;
                        cnt_in     = '0;
                        state_in   = ST_CHECK;
                        if ((in_col_ff == wm1) && (in_row_ff == hm1)) begin
                           full_in = 1'b1;
                        end else if (in_col_ff == wm1) begin
                           in_col_in  = '0;
                           in_row_in  = 12'(in_row_ff + 1'b1);
                           in_ring_in = ring_inc(in_ring_ff);
                        end else begin
                           in_col_in = XW'(in_col_ff + 1'b1);
                        end
                     end
                  end
                  REQ_DRAIN: begin
                     if (full_ff) begin
                        drain_in = 1'b1;
                        cnt_in   = '0;
                        state_in = ST_CHECK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_CHECK: begin
            if (full_ff || out_ready(out_col_ff, out_row_ff)) begin
               i_in     = '0;
               j_in     = '0;
               tx_in    = tx_init;
               tx0_in   = tx_init;
               ty_in    = ty_init;
               caddr_in = '0;
               // ring slot of the first window row; rows above the image clamp to row 0
               if (ty_init[TYW-1]) begin
                  ring_in = '0;
               end else if (out_ring_ff >= RGW'(kh_half)) begin
                  ring_in = RGW'(out_ring_ff - RGW'(kh_half));
               end else begin
                  ring_in = RGW'({1'b0, out_ring_ff} + RGW1'(MAX_KERNEL) - RGW1'(kh_half));
               end
               state_in = ST_ISSUE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ISSUE: begin
            tap_in.shift     = 1'b1;
            tap_in.row_end   = (i_ff == 3'(kw - 3'd1));
            tap_in.first_row = (j_ff == '0);
            tap_in.out_end   = tap_in.row_end && (j_ff == 3'(kh - 3'd1));
            caddr_in         = CAW'(caddr_ff + 1'b1);
            if (!tap_in.row_end) begin
               i_in  = 3'(i_ff + 1'b1);
               tx_in = tx_ff + $signed(TXW'(1));
            end else begin
               i_in  = '0;
               j_in  = 3'(j_ff + 1'b1);
               tx_in = tx0_ff;
               ty_in = ty_ff + $signed(TYW'(1));
               if (!ty_ff[TYW-1] && (ty_ff < $signed({2'b0, hm1}))) begin
                  ring_in = ring_inc(ring_ff);
               end
            end
            if (tap_in.out_end) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (res_valid) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               cnt_in   = 2'(cnt_ff + 1'b1);
               if (frame_end) begin
                  in_col_in   = '0;
                  in_row_in   = '0;
                  in_ring_in  = '0;
                  out_col_in  = '0;
                  out_row_in  = '0;
                  out_ring_in = '0;
                  full_in     = 1'b0;
               end else begin
                  out_col_in  = nxt_col;
                  out_row_in  = nxt_row;
                  out_ring_in = nxt_ring;
               end
               rsp_last_in = drain_ff || frame_end || (cnt_ff == 2'd3) ||
                             !(full_ff || out_ready(nxt_col, nxt_row));
               state_in    = rsp_last_in ? ST_IDLE : ST_CHECK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // geometry change restarts the frame
      if (geo_wr) begin
         in_col_in   = '0;
         in_row_in   = '0;
         in_ring_in  = '0;
         out_col_in  = '0;
         out_row_in  = '0;
         out_ring_in = '0;
         full_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_ring_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_ring_ff <= '0;
         full_ff     <= 1'b0;
         drain_ff    <= 1'b0;
         cnt_ff      <= '0;
         s1_ff       <= '0;
      end else begin
         state_ff    <= state_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_ring_ff  <= in_ring_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         out_ring_ff <= out_ring_in;
         full_ff     <= full_in;
         drain_ff    <= drain_in;
         cnt_ff      <= cnt_in;
         s1_ff       <= tap_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_col_ff <= pix_col_in;
      pix_row_ff <= pix_row_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      tx_ff      <= tx_in;
      tx0_ff     <= tx0_in;
      ty_ff      <= ty_in;
      ring_ff    <= ring_in;
      caddr_ff   <= caddr_in;
   end

   cec2d_chain #(
      .MAX_KERNEL (MAX_KERNEL)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .tap_flags (s1_ff),
      .sample_in (ls_rd_ff),
      .coef_in   (cf_rd_ff),
      .kernel_w  (kw),
      .lane_en   (lane_en),
      .res_valid (res_valid),
      .res       (res)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         if (keep_channels_ff) begin
            rsp_ch0_ff <= res[0];
            rsp_ch1_ff <= res[1];
            rsp_ch2_ff <= res[2];
         end else begin
            rsp_ch0_ff <= $signed(res[0]) + $signed(res[1]) + $signed(res[2]);
            rsp_ch1_ff <= '0;
            rsp_ch2_ff <= '0;
         end
         rsp_x_ff    <= 10'(out_col_ff);
         rsp_y_ff    <= out_row_ff;
         rsp_last_ff <= rsp_last_in;
         rsp_fe_ff   <= frame_end;
      end
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_ch0     = rsp_ch0_ff;
   assign rsp_out_ch1     = rsp_ch1_ff;
   assign rsp_out_ch2     = rsp_ch2_ff;
   assign rsp_out_x       = rsp_x_ff;
   assign rsp_out_y       = rsp_y_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_frame_end   = rsp_fe_ff;

endmodule

// File: sv/cec2d_cell.sv
// one tap cell of the convolution chain: holds a sample and a coefficient,
// passes them to its neighbor and forms the registered per-lane products; uses cec2d_pkg
module cec2d_cell (
   input  logic                       clock,
   input  logic                       shift_en,
   input  logic                       tap_en,
   input  cec2d_pkg::lane_mask_type   lane_en,
   input  cec2d_pkg::pixel_type       sample_in,
   input  cec2d_pkg::coef_type        coef_in,
   output cec2d_pkg::pixel_type       sample_out,
   output cec2d_pkg::coef_type        coef_out,
   output cec2d_pkg::prod_lanes_type  prod_out
);
   import cec2d_pkg::*;

   pixel_type      sample_ff;
   coef_type       coef_ff;
   prod_lanes_type prod_ff;
   prod_lanes_type prod_in;

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         if (tap_en && lane_en[l]) begin
            prod_in[l] = coef_ff * $signed({1'b0, sample_ff[l]});
         end else begin
            prod_in[l] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         sample_ff <= sample_in;
         coef_ff   <= coef_in;
      end
      prod_ff <= prod_in;
   end

   assign sample_out = sample_ff;
   assign coef_out   = coef_ff;
   assign prod_out   = prod_ff;

endmodule

// File: sv/cec2d_chain.sv
// row of tap cells with a two-level registered adder tree and the window accumulator;
// uses cec2d_pkg and cec2d_cell
module cec2d_chain #(
   parameter int MAX_KERNEL = cec2d_pkg::DEF_MAX_KERNEL
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cec2d_pkg::tap_flags_type  tap_flags,
   input  cec2d_pkg::pixel_type      sample_in,
   input  cec2d_pkg::coef_type       coef_in,
   input  logic [2:0]                kernel_w,
   input  cec2d_pkg::lane_mask_type  lane_en,
   output logic                      res_valid,
   output cec2d_pkg::acc_lanes_type  res
);
   import cec2d_pkg::*;

   localparam int NPAIR = (MAX_KERNEL + 1) / 2;

   pixel_type      smp  [MAX_KERNEL];
   coef_type       cf   [MAX_KERNEL];
   prod_lanes_type prod [MAX_KERNEL];

   acc_lanes_type  pair_in [NPAIR];
   acc_lanes_type  pair_ff [NPAIR];
   acc_lanes_type  total;
   acc_lanes_type  acc_ff;
   acc_lanes_type  res_ff;
   logic           res_valid_ff;

   tap_flags_type  s2_ff, s3_ff, s4_ff;

   for (genvar k = 0; k < MAX_KERNEL; k++) begin : g_cell
      cec2d_cell u_cell (
         .clock      (clock),
         .shift_en   (tap_flags.shift),
         .tap_en     (k < int'(kernel_w)),
         .lane_en    (lane_en),
         .sample_in  ((k == 0) ? sample_in : smp[(k == 0) ? 0 : k - 1]),
         .coef_in    ((k == 0) ? coef_in : cf[(k == 0) ? 0 : k - 1]),
         .sample_out (smp[k]),
         .coef_out   (cf[k]),
         .prod_out   (prod[k])
      );
   end

   for (genvar p = 0; p < NPAIR; p++) begin : g_pair
      for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
         if (2 * p + 1 < MAX_KERNEL) begin : g_two
            assign pair_in[p][l] = ACC_W'($signed(prod[2 * p][l]))
                                 + ACC_W'($signed(prod[2 * p + 1][l]));
         end else begin : g_one
            assign pair_in[p][l] = ACC_W'($signed(prod[2 * p][l]));
         end
      end
   end

   // row sum plus what earlier rows of this window left
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         total[l] = s4_ff.first_row ? '0 : acc_ff[l];
         for (int p = 0; p < NPAIR; p++) begin
            total[l] = total[l] + pair_ff[p][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff        <= '0;
         s3_ff        <= '0;
         s4_ff        <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         s2_ff        <= tap_flags;
         s3_ff        <= s2_ff;
         s4_ff        <= s3_ff;
         res_valid_ff <= s4_ff.out_end;
      end
   end

   always_ff @(posedge clock) begin
      pair_ff <= pair_in;
      if (s4_ff.row_end) begin
         acc_ff <= total;
      end
      if (s4_ff.out_end) begin
         res_ff <= total;
      end
   end

   assign res_valid = res_valid_ff;
   assign res       = res_ff;

endmodule
